/* hw/rtl/rfag_pkg.sv */
// Shared types and fixed widths for the ring field alpha generator.
// No dependencies; the interfaces and the top level import this package.
package rfag_pkg;

	localparam int unsigned CoordW = 14;
	localparam int unsigned PixW   = 10;
	localparam int unsigned ModeW  = 2;
	localparam int unsigned CfgW   = 8;
	localparam int unsigned AlphaW = 8;
	localparam int unsigned RadW   = 12;
	localparam int unsigned SqW    = 30;
	localparam int unsigned SqSteps = 15;
	localparam int unsigned RootW  = 15;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_EVAL   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic {
		REG_RING_RADIUS = 1'b0,
		REG_BAND_STEP   = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_MOD,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

/* hw/rtl/rfag_item_if.sv */
// Input channel of the ring field alpha generator: one beat per command.
// Depends on rfag_pkg for the field widths.
interface rfag_item_if import rfag_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ModeW-1:0]    mode;
	logic [CoordW-1:0]   center_x;
	logic [CoordW-1:0]   center_y;
	logic [PixW-1:0]     pixel_x;
	logic [PixW-1:0]     pixel_y;

	modport source (output valid, mode, center_x, center_y, pixel_x, pixel_y, input ready);
	modport sink (input valid, mode, center_x, center_y, pixel_x, pixel_y, output ready);
endinterface

/* hw/rtl/rfag_result_if.sv */
// Output channel of the ring field alpha generator: one alpha per beat.
// Depends on rfag_pkg for the field width.
interface rfag_result_if import rfag_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [AlphaW-1:0] alpha;

	modport source (output valid, alpha, input ready);
	modport sink (input valid, alpha, output ready);
endinterface

/* hw/rtl/ring_field_alpha_generator_top.sv */
// Ring field alpha generator. Clear and append beats complete as they are taken.
// A pixel beat walks the centres (none when the table is empty: one centre a cycle
// through a 20-stage distance pipeline fed by the centre memory), then runs the modulo,
// scaling, division and the load of the result register, which waits while that register
// holds an unaccepted beat. The next beat is taken once the block is back in idle.
// Reset empties the table and loads radius 60, step 15; the memory is not cleared.
module ring_field_alpha_generator_top import rfag_pkg::*; #(
	parameter int unsigned MAX_CENTERS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CfgW-1:0]     cfg_data,
	rfag_item_if.sink           item,
	rfag_result_if.source       result
);

	localparam int unsigned AW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int unsigned CW  = $clog2(MAX_CENTERS + 1);
	localparam int unsigned SW  = RadW + ((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1);
	localparam int unsigned BW  = $clog2(SW);
	localparam int unsigned DW  = RadW + 1;
	localparam int unsigned NW  = RadW + 9;
	localparam int unsigned ENW = 2 * CoordW;

	state_t state_q, state_d;

	logic [CfgW-1:0] radius_q, step_q;
	logic [CW-1:0]   count_q, issue_q;
	logic [ENW-1:0]  mem [MAX_CENTERS];
	logic [ENW-1:0]  rd_q;
	logic [CoordW-1:0] qx_q, qy_q;

	logic [RadW-1:0] r_full, s_full;
	assign r_full = {radius_q, 4'b0};
	assign s_full = {step_q, 4'b0};

	logic accept, issuing, last_issue;
	assign accept     = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign issuing    = (state_q == ST_RUN) && (issue_q < count_q);
	assign last_issue = issuing && (issue_q == count_q - CW'(1));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= CfgW'(60);
			step_q   <= CfgW'(15);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_RING_RADIUS: radius_q <= cfg_data;
				REG_BAND_STEP:   step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Centre memory: written on append beats, read during the walk.
	always_ff @(posedge clk) begin
		if (accept && mode_t'(item.mode) == MODE_APPEND && count_q < CW'(MAX_CENTERS))
			mem[count_q[AW-1:0]] <= {item.center_y, item.center_x};
		rd_q <= mem[issue_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			case (mode_t'(item.mode))
				MODE_CLEAR:  count_q <= '0;
				MODE_APPEND: if (count_q < CW'(MAX_CENTERS)) count_q <= count_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
		end else if (accept) begin
			issue_q <= '0;
		end else if (issuing) begin
			issue_q <= issue_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= {item.pixel_x, 4'b0};
			qy_q <= {item.pixel_y, 4'b0};
		end
	end

	// Distance pipeline: read, differences, squares, sum, square root, ring term.
	logic v_rd, l_rd, v_s1, l_s1, v_s2, l_s2, v_s3, l_s3, v_s4, l_s4;
	logic [CoordW-1:0] dx_s1, dy_s1;
	logic [ENW-1:0]    sx_s2, sy_s2;
	logic [SqW-1:0]    n_s3;
	logic [SqW-1:0]    rem_sq [SqSteps+1];
	logic [SqW-1:0]    root_sq [SqSteps+1];
	logic              v_sq [SqSteps+1];
	logic              l_sq [SqSteps+1];
	logic [RadW-1:0]   term_s4;

	logic [CoordW-1:0] cx, cy;
	assign cx = rd_q[CoordW-1:0];
	assign cy = rd_q[ENW-1:CoordW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rd <= 1'b0; v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_rd <= issuing;
			v_s1 <= v_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_sq[SqSteps];
		end
	end

	always_ff @(posedge clk) begin
		l_rd  <= last_issue;
		l_s1  <= l_rd;
		l_s2  <= l_s1;
		l_s3  <= l_s2;
		l_s4  <= l_sq[SqSteps];
		dx_s1 <= (qx_q >= cx) ? qx_q - cx : cx - qx_q;
		dy_s1 <= (qy_q >= cy) ? qy_q - cy : cy - qy_q;
		sx_s2 <= dx_s1 * dx_s1;
		sy_s2 <= dy_s1 * dy_s1;
		n_s3  <= SqW'(sx_s2) + SqW'(sy_s2);
	end

	assign rem_sq[0]  = n_s3;
	assign root_sq[0] = '0;
	assign v_sq[0]    = v_s3;
	assign l_sq[0]    = l_s3;

	// One root bit per stage, from the top bit pair down.
	for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
		localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (SqSteps - 1 - k));
		logic [SqW-1:0] trial;
		assign trial = root_sq[k] + Bit;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sq[k+1] <= 1'b0;
			else         v_sq[k+1] <= v_sq[k];
		end
		always_ff @(posedge clk) begin
			l_sq[k+1] <= l_sq[k];
			if (rem_sq[k] >= trial) begin
				rem_sq[k+1]  <= rem_sq[k] - trial;
				root_sq[k+1] <= (root_sq[k] >> 1) + Bit;
			end else begin
				rem_sq[k+1]  <= rem_sq[k];
				root_sq[k+1] <= root_sq[k] >> 1;
			end
		end
	end

	logic [RootW-1:0] root_d;
	logic [RootW-1:0] off;
	assign root_d = root_sq[SqSteps][RootW-1:0];
	assign off    = (root_d >= RootW'(r_full)) ? root_d - RootW'(r_full)
		: RootW'(r_full) - root_d;

	always_ff @(posedge clk) begin
		term_s4 <= (off < RootW'(r_full)) ? r_full - off[RadW-1:0] : '0;
	end

	// Accumulation, modulo 2S, triangle fold, scaling and division.
	logic [SW-1:0]     sum_q;
	logic [BW-1:0]     bit_q;
	logic [DW-1:0]     rem_q;
	logic [DW:0]       rem_sh;
	logic [DW-1:0]     dvs;
	logic [RadW-1:0]   t_val;
	logic [RadW+4:0]   t10, s9;
	logic [NW-1:0]     num_q;
	logic [NW-1:0]     dsh;
	logic [2:0]        qb_q;
	logic [AlphaW-1:0] quo_q;
	logic              zero_q;

	assign dvs    = {s_full, 1'b0};
	assign rem_sh = {rem_q, sum_q[bit_q]};
	assign t_val  = (rem_q[RadW-1:0] <= s_full && !rem_q[DW-1])
		? rem_q[RadW-1:0] : RadW'(dvs - rem_q);
	assign t10    = 17'(t_val) * 17'd10;
	assign s9     = 17'(s_full) * 17'd9;
	assign dsh    = NW'(s_full) << qb_q;

	always_ff @(posedge clk) begin
		if (accept)
			sum_q <= '0;
		else if (v_s4)
			sum_q <= sum_q + SW'(term_s4);
		case (state_q)
			ST_RUN: begin
				bit_q  <= BW'(SW - 1);
				rem_q  <= '0;
				zero_q <= (step_q == '0);
			end
			ST_MOD: begin
				rem_q <= (rem_sh >= {1'b0, dvs}) ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
				bit_q <= bit_q - BW'(1);
			end
			ST_PREP: begin
				if (t10 <= s9) zero_q <= 1'b1;
				num_q <= NW'(t10 - s9) * NW'(255);
				qb_q  <= 3'd7;
				quo_q <= '0;
			end
			ST_DIV: begin
				if (num_q >= dsh) begin
					num_q        <= num_q - dsh;
					quo_q[qb_q]  <= 1'b1;
				end
				qb_q <= qb_q - 3'd1;
			end
			default: ;
		endcase
	end

	logic run_done;
	assign run_done = (v_s4 && l_s4) || (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && mode_t'(item.mode) == MODE_EVAL) state_d = ST_RUN;
			ST_RUN:  if (run_done) state_d = ST_MOD;
			ST_MOD:  if (bit_q == '0) state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV:  if (qb_q == 3'd0) state_d = ST_DONE;
			ST_DONE: if (!result.valid || result.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Result register; it holds its beat while the next command proceeds.
	logic out_valid_q;
	logic [AlphaW-1:0] alpha_q;
	logic load_out;
	assign load_out     = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;
	assign result.alpha = alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) alpha_q <= zero_q ? '0 : quo_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_CENTERS))
		else $error("centre count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) v_s4 |-> state_q == ST_RUN)
		else $error("ring term arrived outside the centre walk");
	assert property (@(posedge clk) disable iff (!arst_n) issuing |-> issue_q < count_q)
		else $error("read issued past the filled entries");
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && state_q == ST_IDLE)
		else $error("result load did not complete the pixel");

endmodule

/* sim/tb_ring_field_alpha_generator_top.sv */
// Self-checking testbench for the ring field alpha generator: drives command beats,
// predicts each alpha from its own model of the centre table and compares results.
// Depends on rfag_pkg, rfag_item_if, rfag_result_if and the top level.
module tb_ring_field_alpha_generator_top import rfag_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MaxCenters = 32;
	localparam int unsigned WatchLimit = 20000;
	localparam int unsigned SettleCycles = 400;

	typedef struct packed {
		mode_t              mode;
		logic [CoordW-1:0]  cx;
		logic [CoordW-1:0]  cy;
		logic [PixW-1:0]    px;
		logic [PixW-1:0]    py;
	} cmd_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CfgW-1:0] cfg_data;

	rfag_item_if   item ();
	rfag_result_if result ();

	ring_field_alpha_generator_top #(.MAX_CENTERS(MaxCenters)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item.sink),
		.result   (result.source)
	);

	// Model state
	logic [CfgW-1:0]   radius_px;
	logic [CfgW-1:0]   step_px;
	logic [CoordW-1:0] tab_x [MaxCenters];
	logic [CoordW-1:0] tab_y [MaxCenters];
	int unsigned       n_centers;

	cmd_t              cmd_queue [$];
	logic [AlphaW-1:0] alpha_queue [$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatches;
	int unsigned alphas_checked;
	int unsigned cmds_sent;
	int unsigned quiet_cycles;

	function automatic logic [31:0] int_sqrt(input logic [31:0] n);
		logic [31:0] rem;
		logic [31:0] root;
		logic [31:0] bitv;
		rem = n;
		root = 0;
		bitv = 32'd1 << 30;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] dist_abs(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [AlphaW-1:0] ring_alpha(input logic [PixW-1:0] px,
			input logic [PixW-1:0] py);
		logic [31:0] r;
		logic [31:0] s;
		logic [31:0] sum;
		logic [31:0] d;
		logic [31:0] off;
		logic [31:0] m;
		logic [31:0] t;
		logic [31:0] a;
		logic [31:0] dx;
		logic [31:0] dy;
		r = 32'(radius_px) << 4;
		s = 32'(step_px) << 4;
		sum = 0;
		for (int i = 0; i < n_centers; i++) begin
			dx = dist_abs(32'(px) << 4, 32'(tab_x[i]));
			dy = dist_abs(32'(py) << 4, 32'(tab_y[i]));
			d = int_sqrt(dx * dx + dy * dy);
			off = dist_abs(d, r);
			if (off < r)
				sum = sum + (r - off);
		end
		if (s == 0)
			return '0;
		m = sum % (2 * s);
		t = s - dist_abs(s, m);
		if (10 * t <= 9 * s)
			return '0;
		a = ((10 * t - 9 * s) * 255) / s;
		return (a > 255) ? 8'd255 : a[7:0];
	endfunction

	task automatic apply_cmd(input cmd_t c);
		case (c.mode)
			MODE_CLEAR: n_centers = 0;
			MODE_APPEND: begin
				if (n_centers < MaxCenters) begin
					tab_x[n_centers] = c.cx;
					tab_y[n_centers] = c.cy;
					n_centers++;
				end
			end
			MODE_EVAL: alpha_queue.push_back(ring_alpha(c.px, c.py));
			default: ;
		endcase
	endtask

	function automatic cmd_t make_cmd(input mode_t md, input int unsigned x, input int unsigned y);
		cmd_t c;
		c.mode = md;
		c.cx = CoordW'($urandom);
		c.cy = CoordW'($urandom);
		c.px = PixW'($urandom);
		c.py = PixW'($urandom);
		if (md == MODE_APPEND) begin
			c.cx = CoordW'(x);
			c.cy = CoordW'(y);
		end else if (md == MODE_EVAL) begin
			c.px = PixW'(x);
			c.py = PixW'(y);
		end
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				apply_cmd(cmd_t'({item.mode, item.center_x, item.center_y,
					item.pixel_x, item.pixel_y}));
				cmds_sent++;
			end
			if (!item.valid || item.ready) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_t c;
					c = cmd_queue.pop_front();
					item.valid    <= 1'b1;
					item.mode     <= c.mode;
					item.center_x <= c.cx;
					item.center_y <= c.cy;
					item.pixel_x  <= c.px;
					item.pixel_y  <= c.py;
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and stall generation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				alphas_checked++;
				if (alpha_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected alpha beat %0d", result.alpha);
				end else begin
					logic [AlphaW-1:0] want;
					want = alpha_queue.pop_front();
					if (result.alpha !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("alpha mismatch: expected %0d, got %0d", want,
								result.alpha);
					end
				end
			end
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog over cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchLimit) begin
				$display("watchdog expired with %0d alphas outstanding", alpha_queue.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CfgW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RING_RADIUS)
			radius_px = val;
		else
			step_px = val;
	endtask

	task automatic drain();
		while (cmd_queue.size() != 0 || item.valid || alpha_queue.size() != 0)
			@(posedge clk);
		// appends and clears take effect as they are taken; this is idle settle time
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Mostly a fresh table of a few centres near a random spot, then pixels around it.
	task automatic queue_random(input int unsigned n_items);
		int unsigned k;
		int unsigned bx;
		int unsigned by;
		k = 0;
		while (k < n_items) begin
			int unsigned sel;
			sel = $urandom_range(99);
			bx = $urandom_range(1023);
			by = $urandom_range(1023);
			if (sel < 80) begin
				int unsigned nc;
				nc = $urandom_range(0, 6);
				if ($urandom_range(19) == 0)
					nc = $urandom_range(30, 36);
				cmd_queue.push_back(make_cmd(MODE_CLEAR, 0, 0));
				for (int i = 0; i < nc; i++)
					cmd_queue.push_back(make_cmd(MODE_APPEND,
						((bx * 16) + $urandom_range(4000)) & 16'h3fff,
						((by * 16) + $urandom_range(4000)) & 16'h3fff));
				for (int i = 0; i < 6; i++)
					cmd_queue.push_back(make_cmd(MODE_EVAL,
						(bx + $urandom_range(250)) & 10'h3ff,
						(by + $urandom_range(250)) & 10'h3ff));
				k += nc + 7;
			end else if (sel < 90) begin
				cmd_queue.push_back(make_cmd(MODE_APPEND, $urandom_range(16383),
					$urandom_range(16383)));
				k++;
			end else if (sel < 97) begin
				cmd_queue.push_back(make_cmd(MODE_EVAL, bx, by));
				k++;
			end else begin
				cmd_queue.push_back(make_cmd(MODE_NONE, $urandom, $urandom));
				k++;
			end
		end
	endtask

	initial begin
		int unsigned idle_send [4];
		int unsigned idle_recv [4];
		logic [CfgW-1:0] radii [4];
		logic [CfgW-1:0] steps [4];
		idle_send = '{0, 51, 0, 18};
		idle_recv = '{0, 0, 51, 18};
		radii = '{8'd255, 8'd1, 8'd20, 8'd0};
		steps = '{8'd1, 8'd255, 8'd7, 8'd0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RING_RADIUS;
		cfg_data = '0;
		item.valid = 1'b0;
		item.mode = MODE_NONE;
		item.center_x = '0;
		item.center_y = '0;
		item.pixel_x = '0;
		item.pixel_y = '0;
		result.ready = 1'b0;
		radius_px = 8'd60;
		step_px = 8'd15;
		n_centers = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		alphas_checked = 0;
		cmds_sent = 0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, extremes, full table, overflow, unused mode
		cmd_queue.push_back(make_cmd(MODE_EVAL, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_APPEND, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_APPEND, 16383, 16383));
		cmd_queue.push_back(make_cmd(MODE_APPEND, 16, 960));
		cmd_queue.push_back(make_cmd(MODE_EVAL, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_EVAL, 1023, 1023));
		cmd_queue.push_back(make_cmd(MODE_EVAL, 40, 40));
		cmd_queue.push_back(make_cmd(MODE_EVAL, 1, 60));
		cmd_queue.push_back(make_cmd(MODE_NONE, 16383, 16383));
		cmd_queue.push_back(make_cmd(MODE_EVAL, 60, 0));
		cmd_queue.push_back(make_cmd(MODE_CLEAR, 0, 0));
		cmd_queue.push_back(make_cmd(MODE_EVAL, 30, 30));
		for (int i = 0; i < 34; i++)
			cmd_queue.push_back(make_cmd(MODE_APPEND, 640 + 16 * i, 640));
		cmd_queue.push_back(make_cmd(MODE_EVAL, 50, 50));
		cmd_queue.push_back(make_cmd(MODE_EVAL, 100, 40));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_send[ph];
			recv_stall_pct = idle_recv[ph];
			queue_random(100);
			drain();
			write_reg(REG_RING_RADIUS, radii[ph]);
			write_reg(REG_BAND_STEP, steps[ph]);
			queue_random(100);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_RING_RADIUS, 8'd60);
		write_reg(REG_BAND_STEP, 8'd15);
		queue_random(50);
		drain();

		$display("Sent %0d command beats and checked %0d alpha beats", cmds_sent,
			alphas_checked);
		$display("over five register settings and four idling patterns.");
		if (mismatches == 0 && alpha_queue.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
